// File: sv/rca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rca_pkg
// Shared types and constants of the clip rectangle ALU.
// ----------------------------------------------------------------------------
package rca_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int OPCODE_BITS    = 3;
	localparam int NUM_PIECES     = 4;

	// marker value after reset, before truncation to the coordinate width
	localparam int MARKER_RESET = -32768;

	typedef enum logic [OPCODE_BITS-1:0] {
		OP_INTERSECT = 3'd0,
		OP_BBOX      = 3'd1,
		OP_MERGE     = 3'd2,
		OP_SUBTRACT  = 3'd3,
		OP_VALID     = 3'd4,
		OP_INSIDE    = 3'd5
	} op_t;

	// subtract piece bits, in emission order
	localparam int PIECE_TOP    = 0;
	localparam int PIECE_BOTTOM = 1;
	localparam int PIECE_LEFT   = 2;
	localparam int PIECE_RIGHT  = 3;

	typedef logic [NUM_PIECES-1:0] piece_mask_t;

	typedef struct packed {
		piece_mask_t sel;       // piece taken this beat (one-hot or zero)
		logic        last;
		logic        truth;
		logic        no_piece;
	} piece_ctrl_t;

endpackage : rca_pkg
`default_nettype wire

// File: sv/rca_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rca_alu
// Combinational rectangle operations; picks the next pending subtract piece.
// ----------------------------------------------------------------------------
module rca_alu
	import rca_pkg::*;
#(
	parameter int CW = COORD_BITS_DEF
) (
	input  wire logic [OPCODE_BITS-1:0] opcode,
	input  wire logic signed [CW-1:0]   a_left,
	input  wire logic signed [CW-1:0]   a_top,
	input  wire logic signed [CW-1:0]   a_right,
	input  wire logic signed [CW-1:0]   a_bottom,
	input  wire logic signed [CW-1:0]   b_left,
	input  wire logic signed [CW-1:0]   b_top,
	input  wire logic signed [CW-1:0]   b_right,
	input  wire logic signed [CW-1:0]   b_bottom,
	input  wire logic signed [CW-1:0]   marker,
	input  wire piece_mask_t            done,
	output logic signed [CW-1:0]        r_left,
	output logic signed [CW-1:0]        r_top,
	output logic signed [CW-1:0]        r_right,
	output logic signed [CW-1:0]        r_bottom,
	output piece_ctrl_t                 ctrl
);

	logic signed [CW-1:0] max_l, max_t, min_r, min_b;
	logic signed [CW-1:0] min_l, min_t, max_r, max_b;
	logic signed [CW-1:0] mid_t, mid_b;
	piece_mask_t          piece_en, rem, sel;
	logic                 a_valid, a_inside;

	assign max_l = (a_left   > b_left)   ? a_left   : b_left;
	assign max_t = (a_top    > b_top)    ? a_top    : b_top;
	assign min_r = (a_right  < b_right)  ? a_right  : b_right;
	assign min_b = (a_bottom < b_bottom) ? a_bottom : b_bottom;
	assign min_l = (a_left   < b_left)   ? a_left   : b_left;
	assign min_t = (a_top    < b_top)    ? a_top    : b_top;
	assign max_r = (a_right  > b_right)  ? a_right  : b_right;
	assign max_b = (a_bottom > b_bottom) ? a_bottom : b_bottom;

	// rows left of A once the top and bottom strips are cut away
	assign mid_t = max_t;
	assign mid_b = min_b;

	always_comb begin
		piece_en               = '0;
		piece_en[PIECE_TOP]    = a_top < b_top;
		piece_en[PIECE_BOTTOM] = a_bottom > b_bottom;
		piece_en[PIECE_LEFT]   = a_left < b_left;
		piece_en[PIECE_RIGHT]  = a_right > b_right;
	end

	assign rem = piece_en & ~done;
	assign sel = rem & (~rem + piece_mask_t'(1));

	assign a_valid = !(a_left == marker || a_top == marker || a_right == marker
		|| a_bottom == marker) && (a_left < a_right) && (a_top < a_bottom);
	assign a_inside = (a_left >= b_left) && (a_right <= b_right)
		&& (a_top >= b_top) && (a_bottom <= b_bottom);

	always_comb begin
		r_left        = marker;
		r_top         = marker;
		r_right       = marker;
		r_bottom      = marker;
		ctrl.sel      = '0;
		ctrl.last     = 1'b1;
		ctrl.truth    = 1'b0;
		ctrl.no_piece = 1'b0;
		case (opcode)
			OP_INTERSECT: begin
				r_left   = max_l;
				r_top    = max_t;
				r_right  = min_r;
				r_bottom = min_b;
			end
			OP_BBOX: begin
				r_left   = min_l;
				r_top    = min_t;
				r_right  = max_r;
				r_bottom = max_b;
			end
			OP_MERGE: begin
				if (a_left == b_left && a_right == b_right) begin
					if (!(a_bottom < b_top || b_bottom < a_top)) begin
						r_left   = b_left;
						r_top    = min_t;
						r_right  = b_right;
						r_bottom = max_b;
					end
				end else if (a_top == b_top && a_bottom == b_bottom) begin
					if (!(a_right < b_left || b_right < a_left)) begin
						r_left   = min_l;
						r_top    = b_top;
						r_right  = max_r;
						r_bottom = b_bottom;
					end
				end
			end
			OP_SUBTRACT: begin
				ctrl.sel  = sel;
				ctrl.last = (rem & ~sel) == '0;
				if (rem == '0) begin
					ctrl.no_piece = 1'b1;
				end else if (sel[PIECE_TOP]) begin
					r_left   = a_left;
					r_top    = a_top;
					r_right  = a_right;
					r_bottom = b_top;
				end else if (sel[PIECE_BOTTOM]) begin
					r_left   = a_left;
					r_top    = b_bottom;
					r_right  = a_right;
					r_bottom = a_bottom;
				end else if (sel[PIECE_LEFT]) begin
					r_left   = a_left;
					r_top    = mid_t;
					r_right  = b_left;
					r_bottom = mid_b;
				end else begin
					r_left   = b_right;
					r_top    = mid_t;
					r_right  = a_right;
					r_bottom = mid_b;
				end
			end
			OP_VALID: begin
				r_left     = '0;
				r_top      = '0;
				r_right    = '0;
				r_bottom   = '0;
				ctrl.truth = a_valid;
			end
			OP_INSIDE: begin
				r_left     = '0;
				r_top      = '0;
				r_right    = '0;
				r_bottom   = '0;
				ctrl.truth = a_inside;
			end
			default: begin
				r_left   = marker;
				r_top    = marker;
				r_right  = marker;
				r_bottom = marker;
			end
		endcase
	end

endmodule : rca_alu
`default_nettype wire

// File: sv/clip_rectangle_alu_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: an input beat passes the input register, then the result register.
// Throughput: one input per cycle while the output is not stalled; subtract holds
// the input register until its last piece beat (1 to 4 beats) through the single shared ALU.
// Reset: arst_n clears both valid flags and the piece tracker, and sets the
// invalid marker to -32768 (truncated to COORD_BITS).
// ----------------------------------------------------------------------------
// clip_rectangle_alu_unit
// Rectangle ALU for clipping: intersect, bbox, merge, subtract, tests.
// ----------------------------------------------------------------------------
module clip_rectangle_alu_unit
	import rca_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr_en,
	input  wire logic signed [COORD_BITS-1:0] cfg_wr_data,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [OPCODE_BITS-1:0]       opcode,
	input  wire logic signed [COORD_BITS-1:0] a_left,
	input  wire logic signed [COORD_BITS-1:0] a_top,
	input  wire logic signed [COORD_BITS-1:0] a_right,
	input  wire logic signed [COORD_BITS-1:0] a_bottom,
	input  wire logic signed [COORD_BITS-1:0] b_left,
	input  wire logic signed [COORD_BITS-1:0] b_top,
	input  wire logic signed [COORD_BITS-1:0] b_right,
	input  wire logic signed [COORD_BITS-1:0] b_bottom,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed [COORD_BITS-1:0]      r_left,
	output logic signed [COORD_BITS-1:0]      r_top,
	output logic signed [COORD_BITS-1:0]      r_right,
	output logic signed [COORD_BITS-1:0]      r_bottom,
	output logic                              truth,
	output logic                              no_piece,
	output logic                              last_piece
);

	localparam logic signed [COORD_BITS-1:0] MARKER_RST = COORD_BITS'(MARKER_RESET);

	logic signed [COORD_BITS-1:0] marker_q;
	logic                         valid_s1;
	logic [OPCODE_BITS-1:0]       op_s1;
	logic signed [COORD_BITS-1:0] al_s1, at_s1, ar_s1, ab_s1;
	logic signed [COORD_BITS-1:0] bl_s1, bt_s1, br_s1, bb_s1;
	piece_mask_t                  done_q;

	logic signed [COORD_BITS-1:0] alu_l, alu_t, alu_r, alu_b;
	piece_ctrl_t                  alu_ctrl;

	logic out_valid_q;
	logic signed [COORD_BITS-1:0] r_left_q, r_top_q, r_right_q, r_bottom_q;
	logic truth_q, no_piece_q, last_q;

	logic res_load, in_fire;

	assign res_load = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || (res_load && alu_ctrl.last);
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= MARKER_RST;
		end else if (cfg_wr_en) begin
			marker_q <= cfg_wr_data;
		end
	end

	// input stage: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q   <= '0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (res_load && alu_ctrl.last) begin
				valid_s1 <= 1'b0;
			end
			if (res_load) begin
				done_q <= alu_ctrl.last ? '0 : (done_q | alu_ctrl.sel);
			end
		end
	end

	// input stage: payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1 <= opcode;
			al_s1 <= a_left;
			at_s1 <= a_top;
			ar_s1 <= a_right;
			ab_s1 <= a_bottom;
			bl_s1 <= b_left;
			bt_s1 <= b_top;
			br_s1 <= b_right;
			bb_s1 <= b_bottom;
		end
	end

	rca_alu #(
		.CW(COORD_BITS)
	) u_alu (
		.opcode   (op_s1),
		.a_left   (al_s1),
		.a_top    (at_s1),
		.a_right  (ar_s1),
		.a_bottom (ab_s1),
		.b_left   (bl_s1),
		.b_top    (bt_s1),
		.b_right  (br_s1),
		.b_bottom (bb_s1),
		.marker   (marker_q),
		.done     (done_q),
		.r_left   (alu_l),
		.r_top    (alu_t),
		.r_right  (alu_r),
		.r_bottom (alu_b),
		.ctrl     (alu_ctrl)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			r_left_q   <= alu_l;
			r_top_q    <= alu_t;
			r_right_q  <= alu_r;
			r_bottom_q <= alu_b;
			truth_q    <= alu_ctrl.truth;
			no_piece_q <= alu_ctrl.no_piece;
			last_q     <= alu_ctrl.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign r_left     = r_left_q;
	assign r_top      = r_top_q;
	assign r_right    = r_right_q;
	assign r_bottom   = r_bottom_q;
	assign truth      = truth_q;
	assign no_piece   = no_piece_q;
	assign last_piece = last_q;

endmodule : clip_rectangle_alu_unit
`default_nettype wire
